// ===== rtl/core/rqrs_pkg.sv =====
package rqrs_pkg;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_EVERY  = 2'd1,
      KIND_LINEAR = 2'd2,
      KIND_QUAD   = 2'd3
   } kind_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/core/rqrs_if.sv =====
interface rqrs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coef_a;
   logic signed [31:0] coef_b;
   logic signed [31:0] coef_c;

   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface rqrs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         root_count;
   logic               every_x;
   logic signed [31:0] root_first;
   logic signed [31:0] root_second;
   logic               saturated;

   modport source (output valid, root_count, every_x, root_first, root_second, saturated,
                   input ready);
   modport sink (input valid, root_count, every_x, root_first, root_second, saturated,
                 output ready);
endinterface

// ===== rtl/core/real_quadratic_root_solver.sv =====
// channel   dir  handshake        payload
// req_chan  in   valid/ready      coef_a, coef_b, coef_c (Q16.16 signed)
// rsp_chan  out  valid/ready      root_count, every_x, root_first, root_second, saturated
//
// One request a cycle, sustained unless the queue fills or rsp_chan.ready is held low.
// A request passes the front registers, the queue and the bit-per-stage square-root
// and divide pipelines into the response register.
// Synchronous reset clears only valid state and the queue pointers and count.
// The front stalls only when the queue is full; the back stalls only on rsp_chan.ready.
module real_quadratic_root_solver #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   rqrs_req_if.sink   req_chan,
   rqrs_rsp_if.source rsp_chan
);
   import rqrs_pkg::*;

   localparam int EW = 2 + 3 * COEF_WIDTH + 2 * COEF_WIDTH + 1;

   q_status_type  q_status;
   logic          push, pop;
   logic [EW-1:0] wr_entry, rd_entry;

   rqrs_front #(
      .COEF_WIDTH (COEF_WIDTH),
      .EW         (EW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .entry    (wr_entry)
   );

   rqrs_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .wr_data (wr_entry),
      .rd_data (rd_entry),
      .status  (q_status)
   );

   rqrs_back #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .EW         (EW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .entry    (rd_entry),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/core/rqrs_queue.sv =====
module rqrs_queue #(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   pop,
   input  logic [WIDTH-1:0]       wr_data,
   output logic [WIDTH-1:0]       rd_data,
   output rqrs_pkg::q_status_type status
);
   import rqrs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[head_ff];
   assign status.full  = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

endmodule

// ===== rtl/core/rqrs_front.sv =====
module rqrs_front #(
   parameter int COEF_WIDTH = 32,
   parameter int EW         = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   rqrs_req_if.sink               req_chan,
   input  rqrs_pkg::q_status_type q_status,
   output logic                   push,
   output logic [EW-1:0]          entry
);
   import rqrs_pkg::*;

   localparam int CW = COEF_WIDTH;
   localparam int DW = 2 * CW + 1;

   typedef struct packed {
      kind_type        kind;
      logic [CW-1:0]   a;
      logic [CW-1:0]   b;
      logic [CW-1:0]   c;
      logic [DW-1:0]   disc;
   } entry_type;

   function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
      return v[CW-1] ? CW'(-v) : v;
   endfunction

   logic              en;
   logic              f1_v_ff;
   logic [CW-1:0]     f1_a_ff, f1_b_ff, f1_c_ff;
   logic              f2_v_ff;
   logic [CW-1:0]     f2_a_ff, f2_b_ff, f2_c_ff;
   logic [2*CW-1:0]   bb_ff, bb_in;
   logic [2*CW-1:0]   p_ff, p_in;
   logic [DW-1:0]     bbx, p4;
   logic              neg_ac, have;
   entry_type         e;

   assign en             = !f2_v_ff || !q_status.full;
   assign req_chan.ready = en;
   assign push           = f2_v_ff && !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= req_chan.valid;
         f2_v_ff <= f1_v_ff;
      end
   end

   assign bb_in = (2*CW)'(mag(f1_b_ff)) * (2*CW)'(mag(f1_b_ff));
   assign p_in  = (2*CW)'(mag(f1_a_ff)) * (2*CW)'(mag(f1_c_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         f1_a_ff <= req_chan.coef_a[CW-1:0];
         f1_b_ff <= req_chan.coef_b[CW-1:0];
         f1_c_ff <= req_chan.coef_c[CW-1:0];
         f2_a_ff <= f1_a_ff;
         f2_b_ff <= f1_b_ff;
         f2_c_ff <= f1_c_ff;
         bb_ff   <= bb_in;
         p_ff    <= p_in;
      end
   end

   always_comb begin
      bbx    = DW'(bb_ff);
      p4     = {p_ff[2*CW-2:0], 2'b00};
      neg_ac = (p_ff != '0) && (f2_a_ff[CW-1] != f2_c_ff[CW-1]);
      have   = neg_ac || (p4 <= bbx);
      e.a    = f2_a_ff;
      e.b    = f2_b_ff;
      e.c    = f2_c_ff;
      e.disc = neg_ac ? bbx + p4 : bbx - p4;
      if (f2_a_ff == '0) begin
         if (f2_b_ff != '0) begin
            e.kind = KIND_LINEAR;
         end else if (f2_c_ff == '0) begin
            e.kind = KIND_EVERY;
         end else begin
            e.kind = KIND_NONE;
         end
      end else begin
         e.kind = have ? KIND_QUAD : KIND_NONE;
      end
   end

   assign entry = EW'(e);

endmodule

// ===== rtl/core/rqrs_back.sv =====
module rqrs_back #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int EW         = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rqrs_pkg::q_status_type q_status,
   input  logic [EW-1:0]          entry,
   output logic                   pop,
   rqrs_rsp_if.source             rsp_chan
);
   import rqrs_pkg::*;

   localparam int CW   = COEF_WIDTH;
   localparam int DW   = 2 * CW + 1;
   localparam int RW   = DW + 1;
   localparam int SW   = CW + 1;
   localparam int REMW = CW + 3;
   localparam int SQ   = CW + 1;
   localparam int NW   = CW + 1 + FRAC_BITS;
   localparam int RDW  = CW + 1;
   localparam logic [NW-1:0] MAXP = NW'((64'd1 << (CW - 1)) - 64'd1);

   typedef struct packed {
      kind_type        kind;
      logic [CW-1:0]   a;
      logic [CW-1:0]   b;
      logic [CW-1:0]   c;
      logic [DW-1:0]   disc;
   } entry_type;

   typedef struct packed {
      kind_type        kind;
      logic [CW-1:0]   a;
      logic [CW-1:0]   b;
      logic [CW-1:0]   c;
   } sq_ctl_type;

   typedef struct packed {
      logic [1:0] count;
      logic       every;
      logic       neg0;
      logic       neg1;
   } dv_info_type;

   function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
      return v[CW-1] ? CW'(-v) : v;
   endfunction

   function automatic logic [CW:0] clamp(input logic [NW-1:0] q, input logic neg);
      logic          sat;
      logic [CW-1:0] res;
      if (neg) begin
         sat = q > MAXP + 1'b1;
         res = sat ? CW'(MAXP + 1'b1) : CW'(-q);
      end else begin
         sat = q > MAXP;
         res = sat ? CW'(MAXP) : CW'(q);
      end
      return {sat, res};
   endfunction

   entry_type    e;
   logic         en;

   logic         sq_v_ff    [0:SQ];
   sq_ctl_type   sq_ctl_ff  [0:SQ];
   logic [REMW-1:0] sq_rem_ff  [0:SQ];
   logic [SW-1:0]   sq_root_ff [0:SQ];
   logic [RW-1:0]   sq_rad_ff  [0:SQ];

   logic         dv_v_ff    [0:NW];
   dv_info_type  dv_info_ff [0:NW];
   logic [CW:0]  dv_d_ff    [0:NW];
   logic [NW-1:0] dv_x0_ff  [0:NW];
   logic [NW-1:0] dv_x1_ff  [0:NW];
   logic [RDW-1:0] dv_r0_ff [0:NW];
   logic [RDW-1:0] dv_r1_ff [0:NW];

   sq_ctl_type          pc;
   logic [SW-1:0]       ps;
   logic signed [CW+1:0] bx, sx, cx, n0, n1, nl;
   logic [CW:0]         n0m, n1m, nlm, dq, dl;
   dv_info_type         info_in;
   logic [NW-1:0]       x0_in, x1_in;
   logic [CW:0]         d_in;
   logic [CW:0]         cl0, cl1;

   logic         rsp_v_ff;
   logic [1:0]   cnt_ff;
   logic         every_ff;
   logic [CW-1:0] r0_ff, r1_ff;
   logic         sat_ff;

   assign e   = entry_type'(entry);
   assign en  = !rsp_v_ff || rsp_chan.ready;
   assign pop = en && !q_status.empty;

   // square root, one result bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= !q_status.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ctl_ff[0]  <= '{kind: e.kind, a: e.a, b: e.b, c: e.c};
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_rad_ff[0]  <= RW'(e.disc);
      end
   end

   for (genvar k = 1; k <= SQ; k++) begin : g_sq
      logic [REMW-1:0] rem2, trial;
      logic            ge;

      assign rem2  = {sq_rem_ff[k-1][REMW-3:0], sq_rad_ff[k-1][RW-1:RW-2]};
      assign trial = {sq_root_ff[k-1], 2'b01};
      assign ge    = rem2 >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ctl_ff[k]  <= sq_ctl_ff[k-1];
            sq_rem_ff[k]  <= ge ? rem2 - trial : rem2;
            sq_root_ff[k] <= {sq_root_ff[k-1][SW-2:0], ge};
            sq_rad_ff[k]  <= {sq_rad_ff[k-1][RW-3:0], 2'b00};
         end
      end
   end

   // form numerators and divisor
   always_comb begin
      pc  = sq_ctl_ff[SQ];
      ps  = sq_root_ff[SQ];
      bx  = (CW+2)'($signed(pc.b));
      cx  = (CW+2)'($signed(pc.c));
      sx  = $signed({1'b0, ps});
      n0  = -bx - sx;
      n1  = -bx + sx;
      nl  = -cx;
      n0m = n0[CW+1] ? (CW+1)'(-n0) : (CW+1)'(n0);
      n1m = n1[CW+1] ? (CW+1)'(-n1) : (CW+1)'(n1);
      nlm = nl[CW+1] ? (CW+1)'(-nl) : (CW+1)'(nl);
      dq  = {mag(pc.a), 1'b0};
      dl  = (CW+1)'(mag(pc.b));
      info_in.every = 1'b0;
      case (pc.kind)
         KIND_QUAD: begin
            info_in.count = (ps == '0) ? 2'd1 : 2'd2;
            info_in.neg0  = n0[CW+1] != pc.a[CW-1];
            info_in.neg1  = n1[CW+1] != pc.a[CW-1];
            x0_in         = NW'(n0m) << FRAC_BITS;
            x1_in         = NW'(n1m) << FRAC_BITS;
            d_in          = dq;
         end
         KIND_LINEAR: begin
            info_in.count = 2'd1;
            info_in.neg0  = nl[CW+1] != pc.b[CW-1];
            info_in.neg1  = nl[CW+1] != pc.b[CW-1];
            x0_in         = NW'(nlm) << FRAC_BITS;
            x1_in         = NW'(nlm) << FRAC_BITS;
            d_in          = dl;
         end
         KIND_EVERY: begin
            info_in.count = 2'd0;
            info_in.every = 1'b1;
            info_in.neg0  = 1'b0;
            info_in.neg1  = 1'b0;
            x0_in         = '0;
            x1_in         = '0;
            d_in          = '0;
         end
         default: begin
            info_in.count = 2'd0;
            info_in.neg0  = 1'b0;
            info_in.neg1  = 1'b0;
            x0_in         = '0;
            x1_in         = '0;
            d_in          = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= sq_v_ff[SQ];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_info_ff[0] <= info_in;
         dv_d_ff[0]    <= d_in;
         dv_x0_ff[0]   <= x0_in;
         dv_x1_ff[0]   <= x1_in;
         dv_r0_ff[0]   <= '0;
         dv_r1_ff[0]   <= '0;
      end
   end

   // restoring divide, one quotient bit per stage for both roots
   for (genvar k = 1; k <= NW; k++) begin : g_dv
      logic [CW+1:0] t0, t1, dd;
      logic          ge0, ge1;

      assign dd  = (CW+2)'(dv_d_ff[k-1]);
      assign t0  = {dv_r0_ff[k-1], dv_x0_ff[k-1][NW-1]};
      assign t1  = {dv_r1_ff[k-1], dv_x1_ff[k-1][NW-1]};
      assign ge0 = t0 >= dd;
      assign ge1 = t1 >= dd;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (en) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_info_ff[k] <= dv_info_ff[k-1];
            dv_d_ff[k]    <= dv_d_ff[k-1];
            dv_x0_ff[k]   <= {dv_x0_ff[k-1][NW-2:0], ge0};
            dv_x1_ff[k]   <= {dv_x1_ff[k-1][NW-2:0], ge1};
            dv_r0_ff[k]   <= RDW'(ge0 ? t0 - dd : t0);
            dv_r1_ff[k]   <= RDW'(ge1 ? t1 - dd : t1);
         end
      end
   end

   // clamp and hold the response
   assign cl0 = clamp(dv_x0_ff[NW], dv_info_ff[NW].neg0);
   assign cl1 = clamp(dv_x1_ff[NW], dv_info_ff[NW].neg1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= dv_v_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cnt_ff   <= dv_info_ff[NW].count;
         every_ff <= dv_info_ff[NW].every;
         if (dv_info_ff[NW].count == 2'd0) begin
            r0_ff  <= '0;
            r1_ff  <= '0;
            sat_ff <= 1'b0;
         end else begin
            r0_ff  <= cl0[CW-1:0];
            r1_ff  <= cl1[CW-1:0];
            sat_ff <= cl0[CW] || cl1[CW];
         end
      end
   end

   assign rsp_chan.valid       = rsp_v_ff;
   assign rsp_chan.root_count  = cnt_ff;
   assign rsp_chan.every_x     = every_ff;
   assign rsp_chan.root_first  = 32'($signed(r0_ff));
   assign rsp_chan.root_second = 32'($signed(r1_ff));
   assign rsp_chan.saturated   = sat_ff;

endmodule
